// ===== design/fcsb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcsb_pkg
// Shared widths, register codes and transfer types of the frustum cull block.
// ----------------------------------------------------------------------------
package fcsb_pkg;

    localparam int NUM_CELLS = 6;
    localparam int NUM_ROWS  = 4;
    localparam int ROW_W     = 64;
    localparam int COEF_W    = 16;
    localparam int COORD_W   = 16;
    localparam int RAD_W     = 15;
    localparam int ADDR_W    = 5;
    localparam int REG_SHIFT = 3;
    localparam int REG_IDX_W = ADDR_W - REG_SHIFT;

    // plane and datapath widths
    localparam int NRM_W  = COEF_W + 1;
    localparam int PROD_W = NRM_W + COORD_W;
    localparam int SQ_W   = 2 * COEF_W + 1;
    localparam int NN_W   = SQ_W + 1;
    localparam int RR_W   = 2 * RAD_W;
    localparam int D_W    = PROD_W + 2;
    localparam int MAG_W  = D_W - 1;
    localparam int HALF_W = MAG_W / 2;
    localparam int PP_W   = 2 * HALF_W;
    localparam int RP_W   = RR_W + HALF_W;
    localparam int CMP_W  = 2 * MAG_W;

    localparam logic [REG_IDX_W-1:0] REG_ROW0 = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_ROW1 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_ROW2 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_ROW3 = REG_IDX_W'(3);

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] t_rows;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]          radius;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
    } t_item;

    typedef struct packed {
        logic  valid;
        logic  visible;
        t_item item;
    } t_link;

    // matrix row combined with row 3 for each plane cell
    function automatic logic [REG_IDX_W-1:0] cell_row(input int k);
        logic [REG_IDX_W-1:0] r;
        case (k)
            0, 1:    r = REG_ROW0;
            2, 3:    r = REG_ROW1;
            default: r = REG_ROW2;
        endcase
        return r;
    endfunction

    // plane is row3 minus the row when set, row3 plus the row otherwise
    function automatic logic cell_sub(input int k);
        logic s;
        case (k)
            1, 2, 5: s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== design/fcsb_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcsb_if
// Valid/ready channels for object items and cull results.
// ----------------------------------------------------------------------------
interface fcsb_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [fcsb_pkg::COORD_W-1:0] center_x;
    logic signed [fcsb_pkg::COORD_W-1:0] center_y;
    logic signed [fcsb_pkg::COORD_W-1:0] center_z;
    logic [fcsb_pkg::RAD_W-1:0]          radius;
    logic signed [fcsb_pkg::COORD_W-1:0] box_min_x;
    logic signed [fcsb_pkg::COORD_W-1:0] box_min_y;
    logic signed [fcsb_pkg::COORD_W-1:0] box_min_z;
    logic signed [fcsb_pkg::COORD_W-1:0] box_max_x;
    logic signed [fcsb_pkg::COORD_W-1:0] box_max_y;
    logic signed [fcsb_pkg::COORD_W-1:0] box_max_z;

    modport source (
        output valid, kind, center_x, center_y, center_z, radius,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, kind, center_x, center_y, center_z, radius,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface fcsb_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink (input valid, inside_res, output ready);
endinterface
`default_nettype wire

// ===== design/fcsb_apb_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcsb_apb_regs
// APB register file holding the four 64-bit view-projection matrix rows.
// ----------------------------------------------------------------------------
module fcsb_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fcsb_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fcsb_pkg::ROW_W-1:0]    pwdata,
    output logic      [fcsb_pkg::ROW_W-1:0]    prdata,
    output logic                               pready,
    output fcsb_pkg::t_rows                    o_rows
);

    fcsb_pkg::t_rows                      r_rows;
    fcsb_pkg::t_rows                      n_rows;
    logic [fcsb_pkg::REG_IDX_W-1:0]       w_idx;
    logic                                 w_wr;

    assign w_idx  = paddr[fcsb_pkg::ADDR_W-1:fcsb_pkg::REG_SHIFT];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = r_rows[w_idx];
    assign o_rows = r_rows;

    always_comb begin
        n_rows = r_rows;
        if (w_wr) begin
            case (w_idx)
                fcsb_pkg::REG_ROW0: n_rows[fcsb_pkg::REG_ROW0] = pwdata;
                fcsb_pkg::REG_ROW1: n_rows[fcsb_pkg::REG_ROW1] = pwdata;
                fcsb_pkg::REG_ROW2: n_rows[fcsb_pkg::REG_ROW2] = pwdata;
                fcsb_pkg::REG_ROW3: n_rows[fcsb_pkg::REG_ROW3] = pwdata;
                default:            n_rows = r_rows;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else begin
            r_rows <= n_rows;
        end
    end

endmodule
`default_nettype wire

// ===== design/fcsb_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcsb_cell
// One frustum plane: five-stage test of the passing object, hands the object
// and its running inside flag to the next cell.
// ----------------------------------------------------------------------------
module fcsb_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [fcsb_pkg::ROW_W-1:0]  i_row3,
    input  wire logic [fcsb_pkg::ROW_W-1:0]  i_rowx,
    input  wire logic                        i_sub,
    input  fcsb_pkg::t_link                  i_link,
    output fcsb_pkg::t_link                  o_link
);

    typedef struct packed {
        fcsb_pkg::t_link                      link;
        logic                                 zero;
        logic signed [fcsb_pkg::NRM_W-1:0]    w;
        logic signed [fcsb_pkg::PROD_W-1:0]   p0;
        logic signed [fcsb_pkg::PROD_W-1:0]   p1;
        logic signed [fcsb_pkg::PROD_W-1:0]   p2;
        logic [fcsb_pkg::SQ_W-1:0]            sq0;
        logic [fcsb_pkg::SQ_W-1:0]            sq1;
        logic [fcsb_pkg::SQ_W-1:0]            sq2;
        logic [fcsb_pkg::RR_W-1:0]            rr;
    } t_s1;

    typedef struct packed {
        fcsb_pkg::t_link                      link;
        logic                                 zero;
        logic signed [fcsb_pkg::D_W-1:0]      d;
        logic [fcsb_pkg::NN_W-1:0]            nn;
        logic [fcsb_pkg::RR_W-1:0]            rr;
    } t_s2;

    typedef struct packed {
        fcsb_pkg::t_link                      link;
        logic                                 zero;
        logic                                 neg;
        logic [fcsb_pkg::PP_W-1:0]            aa;
        logic [fcsb_pkg::PP_W-1:0]            ab;
        logic [fcsb_pkg::PP_W-1:0]            bb;
        logic [fcsb_pkg::RP_W-1:0]            rh;
        logic [fcsb_pkg::RP_W-1:0]            rl;
    } t_s3;

    typedef struct packed {
        fcsb_pkg::t_link                      link;
        logic                                 zero;
        logic                                 neg;
        logic [fcsb_pkg::CMP_W-1:0]           lhs;
        logic [fcsb_pkg::CMP_W-1:0]           rhs;
    } t_s4;

    t_s1             r_s1, n_s1;
    t_s2             r_s2, n_s2;
    t_s3             r_s3, n_s3;
    t_s4             r_s4, n_s4;
    fcsb_pkg::t_link r_out, n_out;

    logic signed [fcsb_pkg::NRM_W-1:0]     w_nrm [4];
    logic signed [fcsb_pkg::COORD_W-1:0]   w_ctr [3];
    logic signed [fcsb_pkg::COORD_W-1:0]   w_bmin [3];
    logic signed [fcsb_pkg::COORD_W-1:0]   w_bmax [3];
    logic signed [fcsb_pkg::COORD_W-1:0]   w_crd [3];
    logic signed [fcsb_pkg::PROD_W-1:0]    w_prod [3];
    logic signed [2*fcsb_pkg::NRM_W-1:0]   w_sqf [3];
    logic signed [fcsb_pkg::D_W-1:0]       w_negd;
    logic [fcsb_pkg::MAG_W-1:0]            w_mag;
    logic [fcsb_pkg::HALF_W-1:0]           w_ma;
    logic [fcsb_pkg::HALF_W-1:0]           w_mb;
    logic                                  w_reject;

    // plane derivation, positive vertex select and products
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (i_sub) begin
                w_nrm[c] = fcsb_pkg::NRM_W'(signed'(i_row3[c*fcsb_pkg::COEF_W +: fcsb_pkg::COEF_W]))
                         - fcsb_pkg::NRM_W'(signed'(i_rowx[c*fcsb_pkg::COEF_W +: fcsb_pkg::COEF_W]));
            end else begin
                w_nrm[c] = fcsb_pkg::NRM_W'(signed'(i_row3[c*fcsb_pkg::COEF_W +: fcsb_pkg::COEF_W]))
                         + fcsb_pkg::NRM_W'(signed'(i_rowx[c*fcsb_pkg::COEF_W +: fcsb_pkg::COEF_W]));
            end
        end
        w_ctr[0]  = i_link.item.center_x;
        w_ctr[1]  = i_link.item.center_y;
        w_ctr[2]  = i_link.item.center_z;
        w_bmin[0] = i_link.item.box_min_x;
        w_bmin[1] = i_link.item.box_min_y;
        w_bmin[2] = i_link.item.box_min_z;
        w_bmax[0] = i_link.item.box_max_x;
        w_bmax[1] = i_link.item.box_max_y;
        w_bmax[2] = i_link.item.box_max_z;
        for (int c = 0; c < 3; c++) begin
            if (!i_link.item.kind) begin
                w_crd[c] = w_ctr[c];
            end else if (w_nrm[c][fcsb_pkg::NRM_W-1]) begin
                w_crd[c] = w_bmin[c];
            end else begin
                w_crd[c] = w_bmax[c];
            end
            w_prod[c] = fcsb_pkg::PROD_W'(w_nrm[c]) * fcsb_pkg::PROD_W'(w_crd[c]);
            w_sqf[c]  = (2*fcsb_pkg::NRM_W)'(w_nrm[c]) * (2*fcsb_pkg::NRM_W)'(w_nrm[c]);
        end
        n_s1.link = i_link;
        n_s1.zero = (w_nrm[0] == '0) && (w_nrm[1] == '0) && (w_nrm[2] == '0);
        n_s1.w    = w_nrm[3];
        n_s1.p0   = w_prod[0];
        n_s1.p1   = w_prod[1];
        n_s1.p2   = w_prod[2];
        n_s1.sq0  = w_sqf[0][fcsb_pkg::SQ_W-1:0];
        n_s1.sq1  = w_sqf[1][fcsb_pkg::SQ_W-1:0];
        n_s1.sq2  = w_sqf[2][fcsb_pkg::SQ_W-1:0];
        n_s1.rr   = fcsb_pkg::RR_W'(i_link.item.radius) * fcsb_pkg::RR_W'(i_link.item.radius);
    end

    // distance and squared normal length
    always_comb begin
        n_s2.link = r_s1.link;
        n_s2.zero = r_s1.zero;
        n_s2.d    = fcsb_pkg::D_W'(r_s1.p0) + fcsb_pkg::D_W'(r_s1.p1)
                  + fcsb_pkg::D_W'(r_s1.p2) + (fcsb_pkg::D_W'(r_s1.w) <<< 4);
        n_s2.nn   = fcsb_pkg::NN_W'(r_s1.sq0) + fcsb_pkg::NN_W'(r_s1.sq1)
                  + fcsb_pkg::NN_W'(r_s1.sq2);
        n_s2.rr   = r_s1.rr;
    end

    // partial products of d squared and radius squared times normal length
    always_comb begin
        w_negd    = -r_s2.d;
        w_mag     = r_s2.d[fcsb_pkg::D_W-1] ? w_negd[fcsb_pkg::MAG_W-1:0] : '0;
        w_ma      = w_mag[fcsb_pkg::MAG_W-1:fcsb_pkg::HALF_W];
        w_mb      = w_mag[fcsb_pkg::HALF_W-1:0];
        n_s3.link = r_s2.link;
        n_s3.zero = r_s2.zero;
        n_s3.neg  = r_s2.d[fcsb_pkg::D_W-1];
        n_s3.aa   = fcsb_pkg::PP_W'(w_ma) * fcsb_pkg::PP_W'(w_ma);
        n_s3.ab   = fcsb_pkg::PP_W'(w_ma) * fcsb_pkg::PP_W'(w_mb);
        n_s3.bb   = fcsb_pkg::PP_W'(w_mb) * fcsb_pkg::PP_W'(w_mb);
        n_s3.rh   = fcsb_pkg::RP_W'(r_s2.rr)
                  * fcsb_pkg::RP_W'(r_s2.nn[fcsb_pkg::NN_W-1:fcsb_pkg::HALF_W]);
        n_s3.rl   = fcsb_pkg::RP_W'(r_s2.rr)
                  * fcsb_pkg::RP_W'(r_s2.nn[fcsb_pkg::HALF_W-1:0]);
    end

    // recombine partial products
    always_comb begin
        n_s4.link = r_s3.link;
        n_s4.zero = r_s3.zero;
        n_s4.neg  = r_s3.neg;
        n_s4.lhs  = (fcsb_pkg::CMP_W'(r_s3.aa) << (2*fcsb_pkg::HALF_W))
                  + (fcsb_pkg::CMP_W'(r_s3.ab) << (fcsb_pkg::HALF_W+1))
                  + fcsb_pkg::CMP_W'(r_s3.bb);
        n_s4.rhs  = (fcsb_pkg::CMP_W'(r_s3.rh) << fcsb_pkg::HALF_W)
                  + fcsb_pkg::CMP_W'(r_s3.rl);
    end

    // plane verdict
    always_comb begin
        w_reject      = r_s4.neg && !r_s4.zero
                     && (r_s4.link.item.kind || (r_s4.lhs > r_s4.rhs));
        n_out         = r_s4.link;
        n_out.visible = r_s4.link.visible && !w_reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.link.valid <= 1'b0;
            r_s2.link.valid <= 1'b0;
            r_s3.link.valid <= 1'b0;
            r_s4.link.valid <= 1'b0;
            r_out.valid     <= 1'b0;
        end else if (i_en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_out <= n_out;
        end
    end

    assign o_link = r_out;

endmodule
`default_nettype wire

// ===== design/frustum_cull_sphere_box_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box_top
// Frustum culling of bounding spheres and axis-aligned boxes against the six
// planes of a view-projection matrix held in APB registers.
// ----------------------------------------------------------------------------
// One object is taken every cycle unless the output stalls; its inside flag
// leaves after six plane cells in a row, five register stages each, every cell
// testing one plane and passing the object on. The chain moves as a whole;
// when a result waits at the output and is not taken, every stage holds and no
// new object is taken until the output moves. Matrix rows are written over APB
// (row i at byte address 8*i); each cell reads the rows as an object passes, so
// the user must write rows only while no object is in flight; not enforced.
// ----------------------------------------------------------------------------
module frustum_cull_sphere_box_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fcsb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [fcsb_pkg::ROW_W-1:0]   pwdata,
    output logic      [fcsb_pkg::ROW_W-1:0]   prdata,
    output logic                              pready,
    fcsb_in_if.sink                           i_in,
    fcsb_out_if.source                        o_out
);

    fcsb_pkg::t_rows  w_rows;
    fcsb_pkg::t_link  w_link [fcsb_pkg::NUM_CELLS+1];
    logic             w_en;

    fcsb_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rows  (w_rows)
    );

    // chain advances unless a finished result is stuck at the output
    assign w_en = !w_link[fcsb_pkg::NUM_CELLS].valid || o_out.ready;

    assign i_in.ready                = w_en;
    assign w_link[0].valid           = i_in.valid;
    assign w_link[0].visible         = 1'b1;
    assign w_link[0].item.kind       = i_in.kind;
    assign w_link[0].item.center_x   = i_in.center_x;
    assign w_link[0].item.center_y   = i_in.center_y;
    assign w_link[0].item.center_z   = i_in.center_z;
    assign w_link[0].item.radius     = i_in.radius;
    assign w_link[0].item.box_min_x  = i_in.box_min_x;
    assign w_link[0].item.box_min_y  = i_in.box_min_y;
    assign w_link[0].item.box_min_z  = i_in.box_min_z;
    assign w_link[0].item.box_max_x  = i_in.box_max_x;
    assign w_link[0].item.box_max_y  = i_in.box_max_y;
    assign w_link[0].item.box_max_z  = i_in.box_max_z;

    for (genvar k = 0; k < fcsb_pkg::NUM_CELLS; k++) begin : g_cell
        fcsb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_row3  (w_rows[fcsb_pkg::REG_ROW3]),
            .i_rowx  (w_rows[fcsb_pkg::cell_row(k)]),
            .i_sub   (fcsb_pkg::cell_sub(k)),
            .i_link  (w_link[k]),
            .o_link  (w_link[k+1])
        );
    end

    assign o_out.valid      = w_link[fcsb_pkg::NUM_CELLS].valid;
    assign o_out.inside_res = w_link[fcsb_pkg::NUM_CELLS].visible;

endmodule
`default_nettype wire

// ===== tb/sv/tb_frustum_cull_sphere_box_top.sv =====
// ----------------------------------------------------------------------------
// tb_frustum_cull_sphere_box_top
// Drives spheres and boxes through the cull block under several view matrices
// loaded over APB. Every result is compared with an in-bench plane-distance
// calculation, and a few directed rows also carry a known answer.
// ----------------------------------------------------------------------------
module tb_frustum_cull_sphere_box_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcsb_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int DIR_ROWS     = 24;

    localparam logic KIND_SPHERE = 1'b0;
    localparam logic KIND_BOX    = 1'b1;

    localparam logic [NUM_ROWS-1:0][REG_IDX_W-1:0] ROW_REGS =
        {REG_ROW3, REG_ROW2, REG_ROW1, REG_ROW0};
    // planes that subtract their row from row 3
    localparam logic [NUM_CELLS-1:0] PLANE_NEG = 6'b100110;

    localparam int MODE_RANDOM  = 0;
    localparam int MODE_CAMERA  = 1;
    localparam int MODE_EXTREME = 2;

    typedef enum logic [1:0] {FIX_NONE, FIX_INSIDE, FIX_CULLED} t_fix;

    typedef struct {
        int    cfg;
        t_item obj;
        t_fix  fix;
    } t_dir_row;

    typedef struct {
        logic visible;
        t_fix fix;
        int   seq;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [ROW_W-1:0]  pwdata;
    logic [ROW_W-1:0]  prdata;
    logic              pready;

    fcsb_in_if  in_ch ();
    fcsb_out_if out_ch ();

    frustum_cull_sphere_box_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_rows    matrix_now;
    t_verdict verdicts_due [$];
    t_fix     drv_fix;
    bit       calm;
    int       err_count;
    int       stuck_cycles;
    int       objects_in;
    int       stall_left;
    t_rows    cfg_tab [5];
    t_dir_row dir_tab [DIR_ROWS];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    function automatic longint coef(t_rows m, logic [REG_IDX_W-1:0] r, int c);
        return longint'($signed(m[r][COEF_W*c +: COEF_W]));
    endfunction

    // inside flag of one object against the six planes of matrix m
    function automatic logic frustum_verdict(t_rows m, t_item obj);
        longint nrm [4];
        longint ctr [3];
        longint lo [3];
        longint hi [3];
        longint dval;
        longint nsq;
        logic [127:0] mag;
        logic [127:0] bound;
        logic ins;
        int p;
        int c;
        ins = 1'b1;
        ctr[0] = longint'($signed(obj.center_x));
        ctr[1] = longint'($signed(obj.center_y));
        ctr[2] = longint'($signed(obj.center_z));
        lo[0]  = longint'($signed(obj.box_min_x));
        lo[1]  = longint'($signed(obj.box_min_y));
        lo[2]  = longint'($signed(obj.box_min_z));
        hi[0]  = longint'($signed(obj.box_max_x));
        hi[1]  = longint'($signed(obj.box_max_y));
        hi[2]  = longint'($signed(obj.box_max_z));
        for (p = 0; p < NUM_CELLS; p++) begin
            for (c = 0; c < 4; c++) begin
                if (PLANE_NEG[p]) begin
                    nrm[c] = coef(m, REG_ROW3, c) - coef(m, ROW_REGS[p/2], c);
                end else begin
                    nrm[c] = coef(m, REG_ROW3, c) + coef(m, ROW_REGS[p/2], c);
                end
            end
            if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) continue;
            dval = nrm[3] * 16;
            if (obj.kind == KIND_BOX) begin
                for (c = 0; c < 3; c++) begin
                    dval += nrm[c] * ((nrm[c] >= 0) ? hi[c] : lo[c]);
                end
                if (dval < 0) ins = 1'b0;
            end else begin
                nsq = 0;
                for (c = 0; c < 3; c++) begin
                    dval += nrm[c] * ctr[c];
                    nsq  += nrm[c] * nrm[c];
                end
                if (dval < 0) begin
                    mag   = 128'(-dval);
                    bound = 128'(obj.radius) * 128'(obj.radius) * 128'(nsq);
                    if (mag * mag > bound) ins = 1'b0;
                end
            end
        end
        return ins;
    endfunction

    function automatic t_item sphere_obj(int x, int y, int z, int r);
        t_item o;
        o           = t_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        o.kind      = KIND_SPHERE;
        o.center_x  = COORD_W'(x);
        o.center_y  = COORD_W'(y);
        o.center_z  = COORD_W'(z);
        o.radius    = RAD_W'(r);
        return o;
    endfunction

    function automatic t_item box_obj(int x0, int y0, int z0, int x1, int y1, int z1);
        t_item o;
        o           = t_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        o.kind      = KIND_BOX;
        o.box_min_x = COORD_W'(x0);
        o.box_min_y = COORD_W'(y0);
        o.box_min_z = COORD_W'(z0);
        o.box_max_x = COORD_W'(x1);
        o.box_max_y = COORD_W'(y1);
        o.box_max_z = COORD_W'(z1);
        return o;
    endfunction

    function automatic logic [15:0] spread(int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [15:0] stretch(logic [15:0] base, int ext);
        return 16'(int'($signed(base)) + ext);
    endfunction

    function automatic t_item rand_object(bit near);
        t_item o;
        logic [15:0] tmp;
        o = t_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (near) begin
            o.center_x  = spread(48);
            o.center_y  = spread(48);
            o.center_z  = spread(48);
            o.radius    = RAD_W'($urandom_range(0, 31));
            o.box_min_x = spread(48);
            o.box_min_y = spread(48);
            o.box_min_z = spread(48);
            o.box_max_x = stretch(o.box_min_x, $urandom_range(0, 48));
            o.box_max_y = stretch(o.box_min_y, $urandom_range(0, 48));
            o.box_max_z = stretch(o.box_min_z, $urandom_range(0, 48));
        end
        if ($urandom_range(0, 19) == 0) begin
            tmp         = o.box_min_x;
            o.box_min_x = o.box_max_x;
            o.box_max_x = tmp;
        end
        return o;
    endfunction

    function automatic t_rows make_matrix(int mode);
        t_rows m;
        logic [15:0] picks [6];
        int r;
        int c;
        picks = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h1000};
        m = '0;
        for (r = 0; r < NUM_ROWS; r++) begin
            for (c = 0; c < 4; c++) begin
                case (mode)
                    MODE_RANDOM: begin
                        m[r][COEF_W*c +: COEF_W] = 16'($urandom);
                    end
                    MODE_CAMERA: begin
                        if (r == 3 && c == 3) begin
                            m[r][COEF_W*c +: COEF_W] = 16'($urandom_range(16'h0800, 16'h2000));
                        end else if (r == c) begin
                            m[r][COEF_W*c +: COEF_W] = 16'($urandom_range(16'h0800, 16'h3000));
                        end else begin
                            m[r][COEF_W*c +: COEF_W] = spread(16'h0200);
                        end
                    end
                    default: begin
                        m[r][COEF_W*c +: COEF_W] = picks[$urandom_range(0, 5)];
                    end
                endcase
            end
        end
        return m;
    endfunction

    function automatic int idle_len(bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // wait at a falling edge until every pending result has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (verdicts_due.size() != 0);
    endtask

    task automatic apb_access(bit wr, logic [REG_IDX_W-1:0] idx, logic [ROW_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx) << REG_SHIFT;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr) begin
            matrix_now[idx] = v;
        end else if (prdata !== matrix_now[idx]) begin
            report($sformatf("row %0d read %h, written %h", idx, prdata, matrix_now[idx]));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_matrix(t_rows m);
        int r;
        settle();
        for (r = 0; r < NUM_ROWS; r++) apb_access(1'b1, ROW_REGS[r], m[r]);
        for (r = 0; r < NUM_ROWS; r++) apb_access(1'b0, ROW_REGS[r], '0);
    endtask

    task automatic send_object(t_item o, t_fix fix);
        int gap;
        gap = calm ? 0 : idle_len(1'b1);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.kind      <= o.kind;
        in_ch.center_x  <= o.center_x;
        in_ch.center_y  <= o.center_y;
        in_ch.center_z  <= o.center_z;
        in_ch.radius    <= o.radius;
        in_ch.box_min_x <= o.box_min_x;
        in_ch.box_min_y <= o.box_min_y;
        in_ch.box_min_z <= o.box_min_z;
        in_ch.box_max_x <= o.box_max_x;
        in_ch.box_max_y <= o.box_max_y;
        in_ch.box_max_z <= o.box_max_z;
        in_ch.valid     <= 1'b1;
        drv_fix         <= fix;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result side: random back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len(1'b0);
        end
    end

    always @(posedge i_clk) begin : monitor
        bit       in_hit;
        bit       out_hit;
        t_verdict v;
        t_item    o;
        if (i_rst_n) begin
            in_hit  = in_ch.valid && in_ch.ready;
            out_hit = out_ch.valid && out_ch.ready;
            if (out_hit) begin
                if (verdicts_due.size() == 0) begin
                    report($sformatf("result transfer %b with nothing pending",
                                     out_ch.inside_res));
                end else begin
                    v = verdicts_due.pop_front();
                    if (out_ch.inside_res !== v.visible) begin
                        report($sformatf("object %0d: inside_res %b, predicted %b",
                                         v.seq, out_ch.inside_res, v.visible));
                    end
                    if ((v.fix == FIX_INSIDE && out_ch.inside_res !== 1'b1) ||
                        (v.fix == FIX_CULLED && out_ch.inside_res !== 1'b0)) begin
                        report($sformatf("object %0d: inside_res %b against fixed %s",
                                         v.seq, out_ch.inside_res, v.fix.name()));
                    end
                end
            end
            if (in_hit) begin
                o = '{in_ch.kind, in_ch.center_x, in_ch.center_y, in_ch.center_z,
                      in_ch.radius, in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z,
                      in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z};
                v.visible = frustum_verdict(matrix_now, o);
                v.fix     = drv_fix;
                v.seq     = objects_in;
                objects_in++;
                verdicts_due.push_back(v);
            end
            stuck_cycles = (in_hit || out_hit) ? 0 : stuck_cycles + 1;
        end
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int   k;
        int   ph;
        int   cur_cfg;
        int   mode;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_SPHERE;
        in_ch.center_x  = '0;
        in_ch.center_y  = '0;
        in_ch.center_z  = '0;
        in_ch.radius    = '0;
        in_ch.box_min_x = '0;
        in_ch.box_min_y = '0;
        in_ch.box_min_z = '0;
        in_ch.box_max_x = '0;
        in_ch.box_max_y = '0;
        in_ch.box_max_z = '0;
        out_ch.ready    = 1'b0;
        drv_fix         = FIX_NONE;
        calm            = 1'b0;
        err_count       = 0;
        stuck_cycles    = 0;
        objects_in      = 0;
        stall_left      = 0;
        matrix_now      = '0;

        // reset value, zero normals with negative w, unit cube, two extremes
        cfg_tab[0] = '0;
        cfg_tab[1] = {64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0};
        cfg_tab[2] = {64'h1000_0000_0000_0000, 64'h0000_1000_0000_0000,
                      64'h0000_0000_1000_0000, 64'h0000_0000_0000_1000};
        cfg_tab[3] = {64'h7FFF_7FFF_7FFF_7FFF, {3{64'h8000_8000_8000_8000}}};
        cfg_tab[4] = {64'h8000_8000_8000_8000, {3{64'h7FFF_7FFF_7FFF_7FFF}}};

        dir_tab = '{
            '{0, sphere_obj(0, 0, 0, 0), FIX_INSIDE},
            '{0, sphere_obj(-32768, -32768, -32768, 32767), FIX_INSIDE},
            '{0, box_obj(32767, 32767, 32767, -32768, -32768, -32768), FIX_INSIDE},
            '{0, box_obj(-32768, -32768, -32768, 32767, 32767, 32767), FIX_INSIDE},
            '{1, sphere_obj(32767, 32767, 32767, 0), FIX_INSIDE},
            '{1, box_obj(-32768, -32768, -32768, -32768, -32768, -32768), FIX_INSIDE},
            '{2, sphere_obj(0, 0, 0, 0), FIX_INSIDE},
            '{2, sphere_obj(100, 0, 0, 0), FIX_CULLED},
            '{2, sphere_obj(32, 0, 0, 16), FIX_NONE},
            '{2, sphere_obj(32, 0, 0, 15), FIX_NONE},
            '{2, sphere_obj(0, 0, -40, 0), FIX_CULLED},
            '{2, sphere_obj(0, 0, -32768, 32767), FIX_NONE},
            '{2, box_obj(-16, -16, -16, 16, 16, 16), FIX_INSIDE},
            '{2, box_obj(20, 0, 0, 40, 8, 8), FIX_CULLED},
            '{2, box_obj(-100, -100, -100, -17, 100, 100), FIX_NONE},
            '{2, box_obj(10, 10, 10, -10, -10, -10), FIX_NONE},
            '{3, sphere_obj(32767, 32767, 32767, 32767), FIX_NONE},
            '{3, sphere_obj(-32768, -32768, -32768, 0), FIX_NONE},
            '{3, box_obj(-32768, -32768, -32768, 32767, 32767, 32767), FIX_NONE},
            '{3, box_obj(32767, 32767, 32767, -32768, -32768, -32768), FIX_NONE},
            '{4, sphere_obj(-32768, -32768, -32768, 32767), FIX_NONE},
            '{4, sphere_obj(32767, 32767, 32767, 0), FIX_NONE},
            '{4, box_obj(-32768, -32768, -32768, 32767, 32767, 32767), FIX_NONE},
            '{4, box_obj(32767, 32767, 32767, -32768, -32768, -32768), FIX_NONE}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cur_cfg = 0;
        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].cfg != cur_cfg) begin
                cur_cfg = dir_tab[k].cfg;
                load_matrix(cfg_tab[cur_cfg]);
            end
            send_object(dir_tab[k].obj, dir_tab[k].fix);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            mode = ph % 3;
            load_matrix(make_matrix(mode));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                calm = (ph % 2 == 1) && (k < PHASE_ITEMS / 2);
                if ($urandom_range(0, 149) == 0) settle();
                send_object(rand_object($urandom_range(0, 99) <
                                        ((mode == MODE_CAMERA) ? 75 : 30)), FIX_NONE);
            end
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
